>>> rtl/arm_forward_kinematics_top_defines.svh
// Assertion macros used by the checker file.
`ifndef ARM_FORWARD_KINEMATICS_TOP_DEFINES_SVH
`define ARM_FORWARD_KINEMATICS_TOP_DEFINES_SVH

// Implication checked on every clock, off while in reset.
`define AFK_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication checked on every clock, off while in reset.
`define AFK_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

>>> rtl/afk_pkg.sv
// Types, constants and helper functions of the arm forward kinematics block.
`default_nettype none
package afk_pkg;

	localparam int XW = 34;            // CORDIC x/y, Q2.30 with headroom
	localparam int ZW = 25;            // CORDIC angle, 2^-16 degree
	localparam int LANES = 3;          // base, elbow, wrist
	localparam int ANG_FULL = 23040;
	localparam int ANG_HALF = 11520;
	localparam int ANG_QUARTER = 5760;
	localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [1:0] REG_BASE_HEIGHT = 2'd0;
	localparam logic [1:0] REG_ELBOW_OFFSET = 2'd1;
	localparam logic [1:0] REG_ARM_LENGTH = 2'd2;
	localparam logic [1:0] REG_TOOL_LENGTH = 2'd3;

	typedef struct packed {
		logic [LANES-1:0][XW-1:0] x;
		logic [LANES-1:0][XW-1:0] y;
		logic [LANES-1:0][ZW-1:0] z;
		logic [LANES-1:0]         neg;
		logic [23:0]              slide;
		logic [14:0]              wrist;
	} cordic_word_t;

	// atan(2^-i) in 2^-16 degree
	function automatic logic signed [ZW-1:0] atan_q16(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0: r = 25'sd2949120;
			1: r = 25'sd1740967;
			2: r = 25'sd919879;
			3: r = 25'sd466945;
			4: r = 25'sd234379;
			5: r = 25'sd117304;
			6: r = 25'sd58666;
			7: r = 25'sd29335;
			8: r = 25'sd14668;
			9: r = 25'sd7334;
			10: r = 25'sd3667;
			11: r = 25'sd1833;
			12: r = 25'sd917;
			13: r = 25'sd458;
			14: r = 25'sd229;
			15: r = 25'sd115;
			16: r = 25'sd57;
			17: r = 25'sd29;
			18: r = 25'sd14;
			19: r = 25'sd7;
			20: r = 25'sd4;
			21: r = 25'sd2;
			22: r = 25'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Wrap to +-180 deg, fold into +-90 deg; returns {negate, angle in 2^-16 deg}
	function automatic logic [ZW:0] fold_angle(input logic signed [14:0] a);
		logic signed [15:0] w;
		logic signed [ZW-1:0] z;
		logic neg;
		w = 16'(a);
		neg = 1'b0;
		if (w >= 16'sd11520) w = w - 16'(ANG_FULL);
		if (w < -16'sd11520) w = w + 16'(ANG_FULL);
		if (w > 16'sd5760) begin
			w = w - 16'(ANG_HALF);
			neg = 1'b1;
		end
		if (w < -16'sd5760) begin
			w = w + 16'(ANG_HALF);
			neg = 1'b1;
		end
		z = ZW'(w);
		z = z <<< 10;
		return {neg, z};
	endfunction

	// Q2.30 to Q1.15, round half up, saturate
	function automatic logic signed [15:0] round_q15(input logic signed [XW-1:0] v);
		logic signed [XW:0] t;
		logic signed [15:0] r;
		t = (XW+1)'(v) + 35'sd16384;
		t = t >>> 15;
		if (t > 35'sd32767) r = 16'sd32767;
		else if (t < -35'sd32768) r = -16'sd32768;
		else r = t[15:0];
		return r;
	endfunction

	// Q30 length units to 32-bit length units, round half up, saturate
	function automatic logic signed [31:0] round_pos(input logic signed [63:0] v);
		logic signed [63:0] t;
		logic signed [31:0] r;
		t = (v + 64'sd536870912) >>> 30;
		if (t > 64'sd2147483647) r = 32'sh7fffffff;
		else if (t < -64'sd2147483648) r = 32'sh80000000;
		else r = t[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/afk_cordic_cell.sv
// One CORDIC rotation stage for the three joint angles, with carried payload.
`default_nettype none
module afk_cordic_cell
	import afk_pkg::*;
#(
	parameter int STAGE = 0
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic         vld_in,
	input  wire cordic_word_t d_in,
	output logic              vld_q,
	output cordic_word_t      d_q
);

	localparam logic signed [ZW-1:0] ATAN = atan_q16(STAGE);

	cordic_word_t nxt;

	always_comb begin
		nxt = d_in;
		for (int k = 0; k < LANES; k++) begin
			if (!d_in.z[k][ZW-1]) begin
				nxt.x[k] = $signed(d_in.x[k]) - ($signed(d_in.y[k]) >>> STAGE);
				nxt.y[k] = $signed(d_in.y[k]) + ($signed(d_in.x[k]) >>> STAGE);
				nxt.z[k] = $signed(d_in.z[k]) - ATAN;
			end else begin
				nxt.x[k] = $signed(d_in.x[k]) + ($signed(d_in.y[k]) >>> STAGE);
				nxt.y[k] = $signed(d_in.y[k]) - ($signed(d_in.x[k]) >>> STAGE);
				nxt.z[k] = $signed(d_in.z[k]) + ATAN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end

endmodule
`default_nettype wire

>>> rtl/afk_kin.sv
// Kinematics datapath: sin/cos rounding, products and position sums.
`default_nettype none
module afk_kin
	import afk_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic         vld_in,
	input  wire cordic_word_t d_in,
	input  wire logic [19:0]  base_height,
	input  wire logic [19:0]  elbow_offset,
	input  wire logic [19:0]  arm_length,
	input  wire logic [19:0]  tool_length,
	output logic              vld_out,
	output logic [31:0]       pos_x,
	output logic [31:0]       pos_y,
	output logic [31:0]       pos_z,
	output logic [14:0]       tool_pitch
);

	logic [6:0] vld_q;
	logic [6:0][14:0] pitch_q;

	// stage 0: sign fold and rounding to Q1.15
	logic signed [15:0] sn_s0 [LANES];
	logic signed [15:0] cs_s0 [LANES];
	logic signed [23:0] d2_s0;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < LANES; k++) begin
				if (d_in.neg[k]) begin
					sn_s0[k] <= round_q15(-$signed(d_in.y[k]));
					cs_s0[k] <= round_q15(-$signed(d_in.x[k]));
				end else begin
					sn_s0[k] <= round_q15($signed(d_in.y[k]));
					cs_s0[k] <= round_q15($signed(d_in.x[k]));
				end
			end
			d2_s0 <= $signed(d_in.slide);
		end
	end

	logic signed [20:0] l1, l3, l4, l5;
	assign l1 = $signed({1'b0, base_height});
	assign l3 = $signed({1'b0, elbow_offset});
	assign l4 = $signed({1'b0, arm_length});
	assign l5 = $signed({1'b0, tool_length});

	// stage 1: first products
	logic signed [31:0] c3s4_s1, c4s3_s1, s3s4_s1, c3c4_s1;
	logic signed [36:0] l4s3_s1, l4c3_s1, l3c1_s1, l3s1_s1;
	logic signed [39:0] d2s1_s1, d2c1_s1;
	logic signed [15:0] s1_s1, c1_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			c3s4_s1 <= cs_s0[1] * sn_s0[2];
			c4s3_s1 <= cs_s0[2] * sn_s0[1];
			s3s4_s1 <= sn_s0[1] * sn_s0[2];
			c3c4_s1 <= cs_s0[1] * cs_s0[2];
			l4s3_s1 <= l4 * sn_s0[1];
			l4c3_s1 <= l4 * cs_s0[1];
			l3c1_s1 <= l3 * cs_s0[0];
			l3s1_s1 <= l3 * sn_s0[0];
			d2s1_s1 <= d2_s0 * sn_s0[0];
			d2c1_s1 <= d2_s0 * cs_s0[0];
			s1_s1 <= sn_s0[0];
			c1_s1 <= cs_s0[0];
		end
	end

	// stage 2: tool link terms
	logic signed [32:0] t_sum, u_sum;
	logic signed [53:0] l5t_s2, l5u_s2;
	logic signed [36:0] l4s3_s2, l4c3_s2, l3c1_s2, l3s1_s2;
	logic signed [39:0] d2s1_s2, d2c1_s2;
	logic signed [15:0] s1_s2, c1_s2;

	assign t_sum = 33'(c3s4_s1) + 33'(c4s3_s1);
	assign u_sum = 33'(c3c4_s1) - 33'(s3s4_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			l5t_s2 <= l5 * t_sum;
			l5u_s2 <= l5 * u_sum;
			l4s3_s2 <= l4s3_s1;
			l4c3_s2 <= l4c3_s1;
			l3c1_s2 <= l3c1_s1;
			l3s1_s2 <= l3s1_s1;
			d2s1_s2 <= d2s1_s1;
			d2c1_s2 <= d2c1_s1;
			s1_s2 <= s1_s1;
			c1_s2 <= c1_s1;
		end
	end

	// stage 3: reach and the terms that need no reach
	logic signed [63:0] reach_full;
	logic signed [39:0] reach_s3;
	logic signed [63:0] pxa_s3, pya_s3, pz_s3;
	logic signed [15:0] s1_s3, c1_s3;

	assign reach_full = ((64'(l4s3_s2) <<< 15) + 64'(l5t_s2) + 64'sd16384) >>> 15;

	always_ff @(posedge clk) begin
		if (en) begin
			reach_s3 <= reach_full[39:0];
			pxa_s3 <= (64'(l3c1_s2) - 64'(d2s1_s2)) <<< 15;
			pya_s3 <= (64'(d2c1_s2) + 64'(l3s1_s2)) <<< 15;
			pz_s3 <= (64'(l1) <<< 30) - (64'(l4c3_s2) <<< 15) - 64'(l5u_s2);
			s1_s3 <= s1_s2;
			c1_s3 <= c1_s2;
		end
	end

	// stage 4: base rotation of the reach
	logic signed [55:0] sr_s4, cr_s4;
	logic signed [63:0] pxa_s4, pya_s4, pz_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sr_s4 <= s1_s3 * reach_s3;
			cr_s4 <= c1_s3 * reach_s3;
			pxa_s4 <= pxa_s3;
			pya_s4 <= pya_s3;
			pz_s4 <= pz_s3;
		end
	end

	// stage 5: final sums
	logic signed [63:0] px_s5, py_s5, pz_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s5 <= pxa_s4 + 64'(sr_s4);
			py_s5 <= pya_s4 - 64'(cr_s4);
			pz_s5 <= pz_s4;
		end
	end

	// stage 6: round and saturate
	always_ff @(posedge clk) begin
		if (en) begin
			pos_x <= round_pos(px_s5);
			pos_y <= round_pos(py_s5);
			pos_z <= round_pos(pz_s5);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[5:0], vld_in};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pitch_q <= {pitch_q[5:0], d_in.wrist};
		end
	end

	assign vld_out = vld_q[6];
	assign tool_pitch = pitch_q[6];

endmodule
`default_nettype wire

>>> rtl/arm_forward_kinematics_top.sv
// Top level of the arm forward kinematics block.
// Takes one joint pose per cycle and returns the end-effector position and
// pitch, one result per pose, in order. The pipeline has one fold stage, a chain
// of CORDIC_STAGES rotation cells that work on the base, elbow and wrist angles
// side by side, seven kinematics stages and the output register. The whole
// pipeline holds while a result waits at the output, so a new pose is taken in
// every cycle in which the output is free or being taken. The user must write
// lengths over the register port only while no pose is in flight; not enforced.
`default_nettype none
module arm_forward_kinematics_top
	import afk_pkg::*;
#(
	parameter int CORDIC_STAGES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// base_angle[14:0], slide_extension[38:15], elbow_angle[53:39], wrist_angle[68:54]
	input  wire logic [71:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// pos_x[31:0], pos_y[63:32], pos_z[95:64], tool_pitch[110:96]
	output logic [111:0]     m_axis_tdata,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [19:0] base_height_q, elbow_offset_q, arm_length_q, tool_length_q;
	logic [1:0] reg_idx;

	assign pready = 1'b1;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_height_q <= '0;
			elbow_offset_q <= '0;
			arm_length_q <= '0;
			tool_length_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_BASE_HEIGHT: base_height_q <= pwdata[19:0];
				REG_ELBOW_OFFSET: elbow_offset_q <= pwdata[19:0];
				REG_ARM_LENGTH: arm_length_q <= pwdata[19:0];
				REG_TOOL_LENGTH: tool_length_q <= pwdata[19:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_BASE_HEIGHT: prdata = 32'(base_height_q);
			REG_ELBOW_OFFSET: prdata = 32'(elbow_offset_q);
			REG_ARM_LENGTH: prdata = 32'(arm_length_q);
			REG_TOOL_LENGTH: prdata = 32'(tool_length_q);
			default: prdata = '0;
		endcase
	end

	// global advance: everything moves unless the output word is stuck
	logic adv;
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// fold stage
	cordic_word_t fold_w;
	logic [ZW:0] fz [LANES];

	assign fz[0] = fold_angle(s_axis_tdata[14:0]);
	assign fz[1] = fold_angle(s_axis_tdata[53:39]);
	assign fz[2] = fold_angle(s_axis_tdata[68:54]);

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			fold_w.x[k] = CORDIC_GAIN;
			fold_w.y[k] = '0;
			fold_w.z[k] = fz[k][ZW-1:0];
			fold_w.neg[k] = fz[k][ZW];
		end
		fold_w.slide = s_axis_tdata[38:15];
		fold_w.wrist = s_axis_tdata[68:54];
	end

	logic vld_chain [CORDIC_STAGES+1];
	cordic_word_t w_chain [CORDIC_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_chain[0] <= 1'b0;
		end else if (adv) begin
			vld_chain[0] <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			w_chain[0] <= fold_w;
		end
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		afk_cordic_cell #(.STAGE(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.vld_in (vld_chain[i]),
			.d_in   (w_chain[i]),
			.vld_q  (vld_chain[i+1]),
			.d_q    (w_chain[i+1])
		);
	end

	logic kin_vld;
	logic [31:0] px, py, pz;
	logic [14:0] pitch;

	afk_kin u_kin (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (adv),
		.vld_in       (vld_chain[CORDIC_STAGES]),
		.d_in         (w_chain[CORDIC_STAGES]),
		.base_height  (base_height_q),
		.elbow_offset (elbow_offset_q),
		.arm_length   (arm_length_q),
		.tool_length  (tool_length_q),
		.vld_out      (kin_vld),
		.pos_x        (px),
		.pos_y        (py),
		.pos_z        (pz),
		.tool_pitch   (pitch)
	);

	logic out_vld_q;
	logic [111:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= kin_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {1'b0, pitch, pz, py, px};
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = out_data_q;

endmodule
`default_nettype wire

>>> rtl/afk_checker.sv
// Port-level checker of the arm forward kinematics block, bound to the top level.
`default_nettype none
`include "arm_forward_kinematics_top_defines.svh"
module afk_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic [71:0]  s_axis_tdata,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [111:0] m_axis_tdata,
	input wire logic         psel,
	input wire logic         penable,
	input wire logic         pwrite,
	input wire logic [3:0]   paddr,
	input wire logic [31:0]  pwdata,
	input wire logic [31:0]  prdata,
	input wire logic         pready
);

	// input side stalls exactly when a result word is held at the output
	`AFK_ASSERT_IMP(a_ready_follows_out, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready does not track the output stall")
	`AFK_ASSERT_NXT(a_out_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result word changed")
	`AFK_ASSERT_IMP(a_pitch_top_bit, m_axis_tvalid, !m_axis_tdata[111], "padding bit of result word set")
	`AFK_ASSERT_NXT(a_reg_readback, psel && penable && pwrite && paddr[1:0] == 2'd0, prdata[31:20] == 12'd0, "register read shows bits above the length width")

endmodule

bind arm_forward_kinematics_top afk_checker u_afk_checker (.*);
`default_nettype wire
